// ===== rtl/tme_pkg.sv =====
// ----------------------------------------------------------------------------
// tme_pkg
// shared types and constants for the triangular matrix expression unit
// ----------------------------------------------------------------------------
package tme_pkg;

  localparam int MaxSizeDefault = 8;
  localparam int SizeWidth      = 4;
  localparam int ElemWidth      = 16;
  localparam int SqWidth        = 36;
  localparam int CWidth         = 56;

  typedef struct packed {
    logic signed [ElemWidth-1:0] a_value;
    logic signed [ElemWidth-1:0] b_value;
  } in_item_t;

  typedef struct packed {
    logic signed [CWidth-1:0] c_value;
    logic                     last_out;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear_acc;   // start a new sum
    logic mac;         // accumulate one step's products
    logic sq_phase;    // 1: a*a sums, 0: output sums
    logic write_sq;    // store finished a*a entry
    logic emit;        // drive finished c element
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_OUT  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

// ===== rtl/tme_datapath.sv =====
// ----------------------------------------------------------------------------
// tme_datapath
// matrix stores, two multipliers and two accumulators
// ----------------------------------------------------------------------------
module tme_datapath import tme_pkg::*; #(
  parameter int MAX_SIZE = MaxSizeDefault
) (
  input  logic                           clk,
  input  logic                           load_we,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] load_addr,
  input  in_item_t                       load_item,
  input  dp_cmd_t                        cmd,
  input  logic [$clog2(MAX_SIZE)-1:0]    r,
  input  logic [$clog2(MAX_SIZE)-1:0]    c,
  input  logic [$clog2(MAX_SIZE)-1:0]    k,
  input  logic                           last_elem,
  output out_item_t                      result
);
  localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE*MAX_SIZE) : 1;
  localparam int Depth = MAX_SIZE * MAX_SIZE;

  logic signed [ElemWidth-1:0] a_store [Depth];
  logic signed [ElemWidth-1:0] b_store [Depth];
  logic signed [SqWidth-1:0]   a_squared_store [Depth];

  // read operands, registered
  logic signed [ElemWidth-1:0] op_a1, op_a2, op_b2;
  logic signed [SqWidth-1:0]   op_sq;
  logic                        op_z1, op_z2, op_mac, op_clr, op_sqp, op_wsq, op_emit, op_last;
  logic [AW-1:0]               op_wa;
  // product stage
  logic signed [2*ElemWidth-1:0]  p1;
  logic signed [SqWidth+ElemWidth-1:0] p2;
  logic                        p_mac, p_clr, p_wsq, p_emit, p_last;
  logic [AW-1:0]               p_wa;
  logic signed [CWidth-1:0]    acc1, acc2;
  logic                        e_wsq, e_emit, e_last;
  logic [AW-1:0]               e_wa;

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] row, input logic [IW-1:0] col);
    addr = AW'(row * MAX_SIZE + col);
  endfunction

  always_ff @(posedge clk) begin
    if (load_we) begin
      a_store[load_addr] <= load_item.a_value;
      b_store[load_addr] <= load_item.b_value;
    end
    if (e_wsq) a_squared_store[e_wa] <= SqWidth'(acc1);
  end

  // stage 1: store reads; sq phase: a(r,k)*a(k,c); out: b(r,k)*a(c,k), sq(r,k)*b(k,c)
  always_ff @(posedge clk) begin
    op_a1 <= cmd.sq_phase ? a_store[addr(r, k)] : b_store[addr(r, k)];
    op_z1 <= cmd.sq_phase ? (r > k) : 1'b0;
    op_a2 <= a_store[cmd.sq_phase ? addr(k, c) : addr(c, k)];
    op_z2 <= cmd.sq_phase ? (k > c) : (c > k);
    op_sq <= a_squared_store[addr(r, k)];
    op_b2 <= b_store[addr(k, c)];
    op_mac <= cmd.mac; op_clr <= cmd.clear_acc; op_sqp <= cmd.sq_phase;
    op_wsq <= cmd.write_sq; op_emit <= cmd.emit; op_last <= last_elem;
    op_wa <= addr(r, c);
  end

  // stage 2: signed products
  always_ff @(posedge clk) begin
    if (op_z1 || op_z2) p1 <= '0;
    else                p1 <= op_a1 * op_a2;
    if (op_sqp) p2 <= '0;
    else        p2 <= op_sq * op_b2;
    p_mac <= op_mac; p_clr <= op_clr;
    p_wsq <= op_wsq; p_emit <= op_emit; p_last <= op_last; p_wa <= op_wa;
  end

  // stage 3: accumulate; acc1 holds a*a or b*at, acc2 holds sq*b
  always_ff @(posedge clk) begin
    if (p_mac) begin
      acc1 <= (p_clr ? '0 : acc1) + CWidth'(p1);
      acc2 <= (p_clr ? '0 : acc2) + CWidth'(p2);
    end
    e_wsq <= p_wsq; e_emit <= p_emit; e_last <= p_last; e_wa <= p_wa;
  end

  assign result.c_value  = e_emit ? (acc1 <<< 8) + acc2 : '0;
  assign result.last_out = e_emit & e_last;
endmodule

// ===== rtl/tme_ctrl.sv =====
// ----------------------------------------------------------------------------
// tme_ctrl
// load counter and compute sequencer
// ----------------------------------------------------------------------------
module tme_ctrl import tme_pkg::*; #(
  parameter int MAX_SIZE = MaxSizeDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        cfg_we,
  input  logic [SizeWidth-1:0]        cfg_data,
  output logic                        busy,
  output logic                        load_we,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] load_addr,
  output dp_cmd_t                     cmd,
  output logic [$clog2(MAX_SIZE)-1:0] r,
  output logic [$clog2(MAX_SIZE)-1:0] c,
  output logic [$clog2(MAX_SIZE)-1:0] k,
  output logic                        last_elem
);
  localparam int IW = $clog2(MAX_SIZE);
  localparam int AW = $clog2(MAX_SIZE*MAX_SIZE);
  localparam int Drain = 3;

  state_t state, state_next;
  logic [SizeWidth-1:0] size_reg;
  logic [IW:0] n;
  logic [IW-1:0] lr, lc, nm1;
  logic [1:0] drain;

  always_comb begin
    if (size_reg == '0) n = (IW+1)'(1);
    else if (32'(size_reg) > MAX_SIZE) n = (IW+1)'(MAX_SIZE);
    else n = (IW+1)'(size_reg);
  end
  assign nm1 = IW'(n - 1'b1);

  assign busy      = (state != ST_LOAD);
  assign load_we   = start && !busy;
  assign load_addr = AW'(lr * MAX_SIZE + lc);
  assign last_elem = (r == nm1) && (c == nm1);

  always_comb begin
    cmd = '0;
    cmd.sq_phase  = (state == ST_SQ);
    cmd.mac       = (state == ST_SQ) || (state == ST_OUT);
    cmd.clear_acc = cmd.mac && (k == '0);
    cmd.write_sq  = (state == ST_SQ) && (k == nm1);
    cmd.emit      = (state == ST_OUT) && (k == nm1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (load_we && lr == nm1 && lc == nm1) state_next = ST_SQ;
      ST_SQ:   if (k == nm1 && r == nm1 && c == nm1) state_next = ST_EMIT;
      ST_EMIT: if (drain == 2'(Drain - 1)) state_next = ST_OUT;
      ST_OUT:  if (k == nm1 && r == nm1 && c == nm1) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; size_reg <= SizeWidth'(MAX_SIZE);
      lr <= '0; lc <= '0; r <= '0; c <= '0; k <= '0; drain <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        size_reg <= cfg_data; lr <= '0; lc <= '0;
      end else if (load_we) begin
        if (lc == nm1) begin
          lc <= '0; lr <= (lr == nm1) ? '0 : lr + 1'b1;
        end else lc <= lc + 1'b1;
      end
      // drain waits for the last a*a entry to reach the store
      drain <= (state == ST_EMIT) ? drain + 1'b1 : '0;
      if (state == ST_SQ || state == ST_OUT) begin
        if (k == nm1) begin
          k <= '0;
          if (c == nm1) begin
            c <= '0; r <= (r == nm1) ? '0 : r + 1'b1;
          end else c <= c + 1'b1;
        end else k <= k + 1'b1;
      end
    end
  end
endmodule

// ===== rtl/triangular_matrix_expression.sv =====
// ----------------------------------------------------------------------------
// triangular_matrix_expression
// c = 256*b*transpose(a) + a*a*b for upper triangular a, one shared mac datapath
// ----------------------------------------------------------------------------
// channel   ports                      transaction
// input     start, busy, in_item       start && !busy
// result    out_valid, out_item        out_valid (one cycle, no stall)
// config    cfg_we, cfg_data           cfg_we
//
// loading takes one element per accepted start; the last element starts a compute
// phase of the a*a sums, a drain of the datapath, then the output sums,
// each c element appearing once its last mac has passed the datapath registers
// busy rises once the final load is taken and stays high until the last output
// mac is issued, so the last c element leaves after busy falls
// rst is synchronous and clears the sequencer and sets size to MAX_SIZE
// the receiver cannot stall, results are strobed for one cycle
module triangular_matrix_expression import tme_pkg::*; #(
  parameter int MAX_SIZE = MaxSizeDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  input  logic                 cfg_we,
  input  logic [SizeWidth-1:0] cfg_data,
  output logic                 out_valid,
  output out_item_t            out_item
);
  localparam int IW = $clog2(MAX_SIZE);
  localparam int AW = $clog2(MAX_SIZE*MAX_SIZE);

  logic          load_we, last_elem;
  logic [AW-1:0] load_addr;
  logic [IW-1:0] r, c, k;
  dp_cmd_t       cmd;
  logic [2:0]    emit_pipe;

  tme_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk, .rst, .start, .cfg_we, .cfg_data, .busy, .load_we, .load_addr,
    .cmd, .r, .c, .k, .last_elem
  );

  tme_datapath #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk, .load_we, .load_addr, .load_item(in_item), .cmd, .r, .c, .k,
    .last_elem, .result(out_item)
  );

  // strobe follows emit through the three datapath stages
  always_ff @(posedge clk) begin
    if (rst) emit_pipe <= '0;
    else     emit_pipe <= {emit_pipe[1:0], cmd.emit};
  end
  assign out_valid = emit_pipe[2];

  // no loading while computing
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !load_we) else $error("load while busy");
  // last flag only with a valid result
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    out_item.last_out |-> out_valid) else $error("stray last");
  // a new compute phase never yields a result right after the final one
  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last_out) |=> !out_valid) else $error("result after last");
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the triangular matrix expression unit (c = 256*b*at + a*a*b) against a
// behavioural predictor, with random gaps on the load side and several sizes
// ----------------------------------------------------------------------------
module testbench;
  import tme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Max = MaxSizeDefault;
  localparam int WatchdogLimit = 200000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_item_t in_item;
  logic cfg_we;
  logic [SizeWidth-1:0] cfg_data;
  logic out_valid;
  out_item_t out_item;

  triangular_matrix_expression #(.MAX_SIZE(Max)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // predictor state: loaded elements and current order
  logic signed [ElemWidth-1:0] a_mat [Max*Max];
  logic signed [ElemWidth-1:0] b_mat [Max*Max];
  int unsigned load_pos;
  logic [SizeWidth-1:0] size_reg;

  in_item_t pending_items [$];
  int unsigned pending_gaps [$];
  out_item_t expected_c [$];

  int errors;
  int idle_cycles;
  bit timed_out;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned order_of(logic [SizeWidth-1:0] s);
    if (s == 0) return 1;
    if (s > Max) return Max;
    return s;
  endfunction

  function automatic longint tri_a(int r, int c);
    if (r > c) return 0;
    return longint'(a_mat[r*Max+c]);
  endfunction

  // fold one accepted transaction into the predictor, queue c on load end
  task automatic absorb_element(in_item_t it);
    int unsigned n;
    int unsigned r;
    int unsigned c;
    longint sq [Max*Max];
    longint bat;
    longint aab;
    out_item_t res;
    n = order_of(size_reg);
    if (load_pos >= n*n) load_pos = 0;
    r = load_pos / n;
    c = load_pos % n;
    a_mat[r*Max+c] = it.a_value;
    b_mat[r*Max+c] = it.b_value;
    load_pos++;
    if (load_pos < n*n) return;
    load_pos = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        sq[i*Max+j] = 0;
        for (int k = 0; k < n; k++) sq[i*Max+j] += tri_a(i, k) * tri_a(k, j);
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        bat = 0;
        aab = 0;
        for (int k = 0; k < n; k++) begin
          bat += longint'(b_mat[i*Max+k]) * tri_a(j, k);
          aab += sq[i*Max+k] * longint'(b_mat[k*Max+j]);
        end
        res.c_value = CWidth'(bat * 256 + aab);
        res.last_out = (i*n + j + 1 == n*n);
        expected_c.push_back(res);
      end
  endtask

  // driver: one transaction per queued element, gap drawn per element
  int unsigned gap_left;
  bit gap_loaded;
  bit in_taken;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_loaded = 1'b0;
    end else if (start && !in_taken) begin
      // hold until accepted
    end else if (pending_items.size() == 0) begin
      start <= 1'b0;
    end else begin
      if (!gap_loaded) begin
        gap_left = pending_gaps[0];
        gap_loaded = 1'b1;
      end
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else begin
        start <= 1'b1;
        in_item <= pending_items.pop_front();
        void'(pending_gaps.pop_front());
        gap_loaded = 1'b0;
      end
    end
  end

  // monitor: accepted inputs feed the predictor, results checked in order
  always @(posedge clk) begin
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = start && !busy;
      if (in_taken) absorb_element(in_item);
      if (in_taken || out_valid) idle_cycles <= 0;
      else                       idle_cycles <= idle_cycles + 1;
      if (out_valid) begin
        if (expected_c.size() == 0) begin
          $error("unexpected c element %0d", out_item.c_value);
          errors++;
        end else begin
          if (out_item.c_value !== expected_c[0].c_value) begin
            $error("c_value expected %0d actual %0d",
                   expected_c[0].c_value, out_item.c_value);
            errors++;
          end
          if (out_item.last_out !== expected_c[0].last_out) begin
            $error("last_out expected %0d actual %0d",
                   expected_c[0].last_out, out_item.last_out);
            errors++;
          end
          void'(expected_c.pop_front());
        end
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if (!rst && idle_cycles > WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_element(logic signed [15:0] a, logic signed [15:0] b, bit busy_gap);
    in_item_t it;
    it.a_value = a;
    it.b_value = b;
    pending_items.push_back(it);
    pending_gaps.push_back(busy_gap ? $urandom_range(0, 8) : 0);
  endtask

  // wait until everything is sent and every c element has come out
  task automatic drain();
    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_c.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // idle-only register write
  task automatic write_size(int unsigned s);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= SizeWidth'(s);
    @(posedge clk);
    size_reg = SizeWidth'(s);
    load_pos = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one full load of random content with the given style of gaps
  task automatic random_load(int unsigned n, bit gaps);
    for (int i = 0; i < n*n; i++)
      queue_element(16'($urandom), 16'($urandom), gaps && ($urandom_range(0, 3) != 0));
  endtask

  int unsigned sizes [$];
  int unsigned n;
  int unsigned sent;

  initial begin
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    load_pos = 0;
    size_reg = SizeWidth'(Max);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: order 1 with extreme values
    write_size(1);
    queue_element(16'sh7fff, 16'sh7fff, 0);
    queue_element(-16'sh8000, -16'sh8000, 0);
    queue_element(-16'sh8000, 16'sh7fff, 1);
    queue_element(16'sh0000, 16'shffff, 1);
    drain();
    // order 2 extremes, lower triangle nonzero to confirm it is ignored
    write_size(2);
    for (int i = 0; i < 4; i++) queue_element(-16'sh8000, -16'sh8000, 0);
    for (int i = 0; i < 4; i++) queue_element(16'sh7fff, -16'sh8000, 1);
    drain();
    // register zero is treated as order 1
    write_size(0);
    queue_element(16'sh1234, -16'sh4321, 0);
    drain();
    // above range is treated as the maximum order, also a partial load discard
    write_size(3);
    queue_element(16'sh0101, 16'sh0202, 0);
    drain();
    write_size(15);
    random_load(Max, 1);
    drain();

    // random phases across sizes, extremes included
    sent = 0;
    sizes = '{1, 8, 3, 5, 2, 4, 7, 1};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      n = sizes[p];
      do begin
        random_load(n, ($urandom_range(0, 2) != 0));
        sent += n*n;
      end while (n < 8 && $urandom_range(0, 3) != 0 && sent < 180);
      drain();
    end

    // back to reset order
    write_size(8);
    random_load(8, 0);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
